// File: rtl/tmtw_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmtw_pkg
// Shared types and constants of the text mode terminal writer.
// ----------------------------------------------------------------------------
package tmtw_pkg;

    localparam int COLUMNS     = 80;
    localparam int ROWS        = 25;
    localparam int CELL_COUNT  = ROWS * COLUMNS;
    localparam int ADDR_W      = $clog2(CELL_COUNT);
    localparam int ROW_W       = 5;
    localparam int COL_W       = 7;
    localparam int RAW_W       = ROW_W + COL_W;
    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    localparam logic [ADDR_W-1:0] LAST_CELL   = ADDR_W'(CELL_COUNT - 1);
    localparam logic [ADDR_W-1:0] BOTTOM_BASE = ADDR_W'(CELL_COUNT - COLUMNS);
    localparam logic [ADDR_W-1:0] ROW_STEP    = ADDR_W'(COLUMNS);
    localparam logic [COL_W-1:0]  LAST_COL    = COL_W'(COLUMNS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW    = ROW_W'(ROWS - 1);
    localparam logic [COL_W:0]    COL_LIMIT   = (COL_W + 1)'(COLUMNS);
    localparam logic [ROW_W:0]    ROW_LIMIT   = (ROW_W + 1)'(ROWS);

    localparam logic [7:0] BLANK_CHAR     = 8'h20;
    localparam logic [7:0] CODE_NEWLINE   = 8'd10;
    localparam logic [7:0] CODE_BACKSPACE = 8'd8;
    localparam logic [7:0] RESET_COLOR    = 8'h0F;

    localparam logic [1:0] OP_PUT   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    typedef struct packed {
        logic [1:0]       operation;
        logic [7:0]       char_code;
        logic [ROW_W-1:0] read_row;
        logic [COL_W-1:0] read_column;
    } in_t;

    typedef struct packed {
        logic [15:0]      cell_data;
        logic [ROW_W-1:0] cursor_row;
        logic [COL_W-1:0] cursor_column;
        logic             scrolled;
    } out_t;

    typedef enum logic [2:0] {
        K_CHAR,
        K_NEWLINE,
        K_BACKSPACE,
        K_CLEAR,
        K_READ,
        K_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t         kind;
        logic [7:0]        char_code;
        logic              read_ok;
        logic [ADDR_W-1:0] read_addr;
    } cmd_t;

    typedef struct packed {
        logic init_busy;
        logic q_full;
    } front_ctl_t;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_READ,
        ST_CLEAR,
        ST_SCROLL,
        ST_BLANK
    } back_state_t;

endpackage
`default_nettype wire

// File: rtl/tmtw_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmtw_front
// Accepts input transactions, decodes them into commands and computes the
// linear cell address of a read.
// ----------------------------------------------------------------------------
module tmtw_front (
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire tmtw_pkg::in_t   s_data,
    input  wire tmtw_pkg::front_ctl_t ctl,
    output logic                 q_push,
    output tmtw_pkg::cmd_t       q_cmd
);

    logic [tmtw_pkg::RAW_W-1:0] raw_addr;

    assign s_ready = !ctl.q_full && !ctl.init_busy;
    assign q_push  = s_valid && s_ready;

    assign raw_addr = tmtw_pkg::RAW_W'(s_data.read_row) * tmtw_pkg::RAW_W'(tmtw_pkg::COLUMNS)
                    + tmtw_pkg::RAW_W'(s_data.read_column);

    always_comb begin
        q_cmd.char_code = s_data.char_code;
        q_cmd.read_addr = tmtw_pkg::ADDR_W'(raw_addr);
        q_cmd.read_ok   = ({1'b0, s_data.read_row} < tmtw_pkg::ROW_LIMIT)
                       && ({1'b0, s_data.read_column} < tmtw_pkg::COL_LIMIT);
        unique case (s_data.operation)
            tmtw_pkg::OP_PUT: begin
                if (s_data.char_code == tmtw_pkg::CODE_NEWLINE) begin
                    q_cmd.kind = tmtw_pkg::K_NEWLINE;
                end else if (s_data.char_code == tmtw_pkg::CODE_BACKSPACE) begin
                    q_cmd.kind = tmtw_pkg::K_BACKSPACE;
                end else begin
                    q_cmd.kind = tmtw_pkg::K_CHAR;
                end
            end
            tmtw_pkg::OP_CLEAR: q_cmd.kind = tmtw_pkg::K_CLEAR;
            tmtw_pkg::OP_READ:  q_cmd.kind = tmtw_pkg::K_READ;
            default:            q_cmd.kind = tmtw_pkg::K_NOP;
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/tmtw_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmtw_queue
// Short command queue between the decode front end and the screen engine.
// ----------------------------------------------------------------------------
module tmtw_queue (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire tmtw_pkg::cmd_t push_cmd,
    input  wire logic           pop,
    output logic                full,
    output logic                not_empty,
    output tmtw_pkg::cmd_t      head_cmd
);

    tmtw_pkg::cmd_t                entry_reg [tmtw_pkg::QUEUE_DEPTH];
    logic [tmtw_pkg::PTR_W-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [tmtw_pkg::PTR_W-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [tmtw_pkg::CNT_W-1:0]    count_reg, count_next;

    localparam logic [tmtw_pkg::PTR_W-1:0] LAST_PTR = tmtw_pkg::PTR_W'(tmtw_pkg::QUEUE_DEPTH - 1);
    localparam logic [tmtw_pkg::CNT_W-1:0] FULL_CNT = tmtw_pkg::CNT_W'(tmtw_pkg::QUEUE_DEPTH);

    assign full      = (count_reg == FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign head_cmd  = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

// File: rtl/tmtw_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmtw_back
// Screen engine: cell memory, cursor, color register, fill and scroll
// sweeps, and the result register.
// ----------------------------------------------------------------------------
module tmtw_back (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           cfg_wr_en,
    input  wire logic [7:0]     cfg_wr_data,
    input  wire logic           q_valid,
    input  wire tmtw_pkg::cmd_t q_cmd,
    output logic                q_pop,
    output logic                init_busy,
    output logic                m_valid,
    input  wire logic           m_ready,
    output tmtw_pkg::out_t      m_data
);

    localparam int AW = tmtw_pkg::ADDR_W;

    logic [15:0]   mem [tmtw_pkg::CELL_COUNT];
    logic [15:0]   rd_data_reg;

    tmtw_pkg::back_state_t state_reg, state_next;

    logic [tmtw_pkg::ROW_W-1:0] row_reg, row_next;
    logic [tmtw_pkg::COL_W-1:0] col_reg, col_next;
    logic [AW-1:0]              base_reg, base_next;
    logic [AW-1:0]              sweep_reg, sweep_next;
    logic                       copy_pend_reg, copy_pend_next;
    logic [AW-1:0]              copy_addr_reg, copy_addr_next;
    logic                       read_ok_reg, read_ok_next;
    logic [7:0]                 color_reg, color_next;
    logic                       out_valid_reg, out_valid_next;
    tmtw_pkg::out_t             out_reg, out_next;

    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic [15:0]   wr_data;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] cell_addr;
    logic          slot_free;
    logic          sweep_last;
    logic          at_last_col;
    logic          at_last_row;

    assign cell_addr   = base_reg + AW'(col_reg);
    assign slot_free   = !out_valid_reg || m_ready;
    assign sweep_last  = (sweep_reg == tmtw_pkg::LAST_CELL);
    assign at_last_col = (col_reg == tmtw_pkg::LAST_COL);
    assign at_last_row = (row_reg == tmtw_pkg::LAST_ROW);
    assign init_busy   = (state_reg == tmtw_pkg::ST_INIT);
    assign m_valid     = out_valid_reg;
    assign m_data      = out_reg;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            tmtw_pkg::ST_INIT: begin
                if (sweep_last) state_next = tmtw_pkg::ST_IDLE;
            end
            tmtw_pkg::ST_IDLE: begin
                if (q_valid && slot_free) begin
                    unique case (q_cmd.kind)
                        tmtw_pkg::K_CLEAR: state_next = tmtw_pkg::ST_CLEAR;
                        tmtw_pkg::K_READ:  state_next = tmtw_pkg::ST_READ;
                        tmtw_pkg::K_CHAR: begin
                            if (at_last_col && at_last_row) state_next = tmtw_pkg::ST_SCROLL;
                        end
                        tmtw_pkg::K_NEWLINE: begin
                            if (at_last_row) state_next = tmtw_pkg::ST_SCROLL;
                        end
                        default: state_next = tmtw_pkg::ST_IDLE;
                    endcase
                end
            end
            tmtw_pkg::ST_READ: state_next = tmtw_pkg::ST_IDLE;
            tmtw_pkg::ST_CLEAR: begin
                if (sweep_last) state_next = tmtw_pkg::ST_IDLE;
            end
            tmtw_pkg::ST_SCROLL: begin
                if (sweep_last) state_next = tmtw_pkg::ST_BLANK;
            end
            tmtw_pkg::ST_BLANK: begin
                if (!copy_pend_reg && sweep_last) state_next = tmtw_pkg::ST_IDLE;
            end
            default: state_next = tmtw_pkg::ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb begin
        logic line_adv;
        logic emit;
        line_adv       = 1'b0;
        emit           = 1'b0;
        row_next       = row_reg;
        col_next       = col_reg;
        base_next      = base_reg;
        sweep_next     = sweep_reg;
        copy_pend_next = 1'b0;
        copy_addr_next = copy_addr_reg;
        read_ok_next   = read_ok_reg;
        color_next     = cfg_wr_en ? cfg_wr_data : color_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;
        q_pop          = 1'b0;
        wr_en          = 1'b0;
        wr_addr        = cell_addr;
        wr_data        = {color_reg, tmtw_pkg::BLANK_CHAR};
        rd_addr        = sweep_reg;

        if (copy_pend_reg) begin
            wr_en   = 1'b1;
            wr_addr = copy_addr_reg;
            wr_data = rd_data_reg;
        end

        unique case (state_reg)
            tmtw_pkg::ST_INIT: begin
                wr_en      = 1'b1;
                wr_addr    = sweep_reg;
                wr_data    = {tmtw_pkg::RESET_COLOR, tmtw_pkg::BLANK_CHAR};
                sweep_next = sweep_last ? '0 : sweep_reg + 1'b1;
            end
            tmtw_pkg::ST_IDLE: begin
                if (q_valid && slot_free) begin
                    q_pop = 1'b1;
                    unique case (q_cmd.kind)
                        tmtw_pkg::K_CHAR: begin
                            wr_en   = 1'b1;
                            wr_data = {color_reg, q_cmd.char_code};
                            if (at_last_col) begin
                                line_adv = 1'b1;
                            end else begin
                                col_next = col_reg + 1'b1;
                                emit     = 1'b1;
                            end
                        end
                        tmtw_pkg::K_NEWLINE: line_adv = 1'b1;
                        tmtw_pkg::K_BACKSPACE: begin
                            if (col_reg != '0) begin
                                col_next = col_reg - 1'b1;
                                wr_en    = 1'b1;
                                wr_addr  = cell_addr - 1'b1;
                            end
                            emit = 1'b1;
                        end
                        tmtw_pkg::K_CLEAR: begin
                            row_next   = '0;
                            col_next   = '0;
                            base_next  = '0;
                            sweep_next = '0;
                        end
                        tmtw_pkg::K_READ: begin
                            rd_addr      = q_cmd.read_addr;
                            read_ok_next = q_cmd.read_ok;
                        end
                        default: emit = 1'b1;
                    endcase
                    if (line_adv) begin
                        col_next = '0;
                        if (at_last_row) begin
                            sweep_next = tmtw_pkg::ROW_STEP;
                        end else begin
                            row_next  = row_reg + 1'b1;
                            base_next = base_reg + tmtw_pkg::ROW_STEP;
                            emit      = 1'b1;
                        end
                    end
                    if (emit) begin
                        out_valid_next         = 1'b1;
                        out_next.cell_data     = '0;
                        out_next.cursor_row    = row_next;
                        out_next.cursor_column = col_next;
                        out_next.scrolled      = 1'b0;
                    end
                end
            end
            tmtw_pkg::ST_READ: begin
                out_valid_next         = 1'b1;
                out_next.cell_data     = read_ok_reg ? rd_data_reg : '0;
                out_next.cursor_row    = row_reg;
                out_next.cursor_column = col_reg;
                out_next.scrolled      = 1'b0;
            end
            tmtw_pkg::ST_CLEAR: begin
                wr_en      = 1'b1;
                wr_addr    = sweep_reg;
                sweep_next = sweep_reg + 1'b1;
                if (sweep_last) begin
                    out_valid_next         = 1'b1;
                    out_next.cell_data     = '0;
                    out_next.cursor_row    = row_reg;
                    out_next.cursor_column = col_reg;
                    out_next.scrolled      = 1'b0;
                end
            end
            tmtw_pkg::ST_SCROLL: begin
                // read row r+1 now, write it to row r on the next cycle
                copy_pend_next = 1'b1;
                copy_addr_next = sweep_reg - tmtw_pkg::ROW_STEP;
                sweep_next     = sweep_last ? tmtw_pkg::BOTTOM_BASE : sweep_reg + 1'b1;
            end
            tmtw_pkg::ST_BLANK: begin
                if (!copy_pend_reg) begin
                    wr_en      = 1'b1;
                    wr_addr    = sweep_reg;
                    sweep_next = sweep_reg + 1'b1;
                    if (sweep_last) begin
                        out_valid_next         = 1'b1;
                        out_next.cell_data     = '0;
                        out_next.cursor_row    = row_reg;
                        out_next.cursor_column = col_reg;
                        out_next.scrolled      = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= tmtw_pkg::ST_INIT;
            row_reg       <= '0;
            col_reg       <= '0;
            base_reg      <= '0;
            sweep_reg     <= '0;
            copy_pend_reg <= 1'b0;
            color_reg     <= tmtw_pkg::RESET_COLOR;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            base_reg      <= base_next;
            sweep_reg     <= sweep_next;
            copy_pend_reg <= copy_pend_next;
            color_reg     <= color_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        copy_addr_reg <= copy_addr_next;
        read_ok_reg   <= read_ok_next;
        out_reg       <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

endmodule
`default_nettype wire

// File: rtl/text_mode_terminal_writer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// text_mode_terminal_writer
// Text screen of ROWS x COLUMNS cells with a cursor; put, clear and read.
// ----------------------------------------------------------------------------
// Usage:
//   s_valid/s_ready/s_data carry commands (put, clear, read). Every accepted
//   transaction yields exactly one result on m_valid/m_ready/m_data, in order.
//   cfg_wr_en/cfg_wr_data set the color attribute; write it only while idle.
// Path from input acceptance to the result register:
//   put character, newline, backspace, unused code: queue, then result register
//   read: queue, registered memory read, then result register
//   clear: queue, sweep over all cells (one cell written per cycle), result
//   put that scrolls: queue, copy sweep of CELL_COUNT - COLUMNS cells, the
//   last copy write, COLUMNS blank writes, then result register
// Throughput: one simple put per cycle while m_ready is high; the memory's
// single write port sets the sweep lengths. A two-entry queue lets input be
// taken while the engine is busy or a result waits.
// Reset: a fill pass writes all CELL_COUNT cells (2000 at 80 x 25) blank with
// color 0x0F; s_ready stays low until it ends. Config writes are taken.
// Stall: while m_ready is low the result holds, the engine waits and the queue
// fills, then s_ready drops.
// ----------------------------------------------------------------------------
module text_mode_terminal_writer (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          cfg_wr_en,
    input  wire logic [7:0]    cfg_wr_data,
    input  wire logic          s_valid,
    output logic               s_ready,
    input  wire tmtw_pkg::in_t s_data,
    output logic               m_valid,
    input  wire logic          m_ready,
    output tmtw_pkg::out_t     m_data
);

    tmtw_pkg::front_ctl_t ctl;
    tmtw_pkg::cmd_t       push_cmd;
    tmtw_pkg::cmd_t       head_cmd;
    logic                 q_push;
    logic                 q_pop;
    logic                 q_full;
    logic                 q_valid;
    logic                 init_busy;

    assign ctl.init_busy = init_busy;
    assign ctl.q_full    = q_full;

    tmtw_front u_front (
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .ctl     (ctl),
        .q_push  (q_push),
        .q_cmd   (push_cmd)
    );

    tmtw_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_valid),
        .head_cmd  (head_cmd)
    );

    tmtw_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .q_valid     (q_valid),
        .q_cmd       (head_cmd),
        .q_pop       (q_pop),
        .init_busy   (init_busy),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule
`default_nettype wire

// File: rtl/tmtw_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// tmtw_checker
// Port-level assertions for the text mode terminal writer.
// ----------------------------------------------------------------------------
module tmtw_checker (
    input wire logic           aclk,
    input wire logic           aresetn,
    input wire logic           s_ready,
    input wire logic           m_valid,
    input wire logic           m_ready,
    input wire tmtw_pkg::out_t m_data
);

    // result holds while stalled
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("stalled result changed");

    // fill pass after reset keeps the input closed
    assert property (@(posedge aclk) !aresetn |=> !s_ready)
        else $error("input ready during reset fill");

    // cursor stays on screen
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ({1'b0, m_data.cursor_row} < tmtw_pkg::ROW_LIMIT)
                 && ({1'b0, m_data.cursor_column} < tmtw_pkg::COL_LIMIT))
        else $error("cursor off screen");

    // a scroll leaves the cursor at the start of the last row, no cell data
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.scrolled |-> (m_data.cursor_row == tmtw_pkg::LAST_ROW)
                 && (m_data.cursor_column == '0) && (m_data.cell_data == '0))
        else $error("bad cursor after scroll");

endmodule

bind text_mode_terminal_writer tmtw_checker u_tmtw_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
`default_nettype wire
